@@ rtl/oahi_pkg.sv @@
// Shared types, codes and constants of the open-addressing hash insert block.
package oahi_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int KEY_W         = 31;

    localparam logic [10:0] SIZE_RESET  = 11'd1021;
    localparam logic [1:0]  MODE_RESET  = 2'd0;
    localparam logic [9:0]  PRIME_RESET = 10'd23;

    localparam logic [1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] CFG_PROBE_MODE = 2'd1;
    localparam logic [1:0] CFG_STEP_PRIME = 2'd2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;

    localparam logic [1:0] MODE_QUAD   = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FAILED   = 2'd1;
    localparam logic [1:0] ST_CLEARED  = 2'd2;
    localparam logic [1:0] ST_READ     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_READ_WAIT,
        S_RESPOND
    } state_t;

    typedef enum logic [1:0] {
        PH_HOME,
        PH_KEYMOD,
        PH_STEP
    } div_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] key;
        logic [9:0]  slot_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  placed_slot;
        logic [10:0] probe_count;
        logic        slot_occupied;
        logic [30:0] slot_key;
        logic [31:0] total_probes;
        logic [10:0] insert_count;
        logic [31:0] failure_count;
    } rsp_t;

endpackage

@@ rtl/open_addressing_hash_insert.sv @@
// Top level of the open-addressing hash insert block.
//
// Usage: raise start with a command word on cmd while busy is low; the word
// is taken at that clock edge and busy rises. An insert stores cmd.key in the
// first free slot of its probe sequence, a clear empties every slot and zeroes
// the statistics, and a read (kind two or three) returns one slot's contents.
// Every command returns exactly one result word on rsp, marked by done for a
// single cycle; the receiver cannot stall, so the word must be taken then.
// An insert runs key mod size through the shared bit-serial remainder unit
// (with double hashing it also needs key mod prime and the step mod size),
// then probes; each probe is one registered read of the slot memory and a
// check of the word read. One command is in flight at a time. After reset the
// block sweeps the whole slot memory with busy high, then accepts commands.
// Configuration words on the write port are taken whenever cfg_we is high and
// must only be written while the block is idle.
module open_addressing_hash_insert #(
    parameter int TABLE_DEPTH = oahi_pkg::DEFAULT_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  oahi_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output oahi_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [10:0]    cfg_data
);
    import oahi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = (SW > 10) ? SW : 10;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    // Configuration registers.
    logic [10:0] table_size_reg;
    logic [1:0]  probe_mode_reg;
    logic [9:0]  step_prime_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            table_size_reg <= SIZE_RESET;
            probe_mode_reg <= MODE_RESET;
            step_prime_reg <= PRIME_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                CFG_PROBE_MODE: probe_mode_reg <= cfg_data[1:0];
                CFG_STEP_PRIME: step_prime_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Effective size is clamped to 1..TABLE_DEPTH and the prime to at least two.
    logic [SW-1:0] size_eff;
    logic [9:0]    prime_eff;

    always_comb begin
        if (table_size_reg == 11'd0) begin
            size_eff = SW'(1);
        end else if (32'(table_size_reg) > TABLE_DEPTH) begin
            size_eff = SW'(TABLE_DEPTH);
        end else begin
            size_eff = SW'(table_size_reg);
        end
        prime_eff = (step_prime_reg < 10'd2) ? 10'd2 : step_prime_reg;
    end

    // Sequencer and datapath registers.
    state_t        state_reg, state_next;
    div_phase_t    phase_reg, phase_next;
    logic [30:0]   key_reg, key_next;
    logic [30:0]   num_reg, num_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [SW-1:0] inc_reg, inc_next;
    logic [SW-1:0] c_reg, c_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          clr_reply_reg, clr_reply_next;
    logic          rd_ok_reg, rd_ok_next;

    logic [1:0]    status_reg, status_next;
    logic [9:0]    placed_reg, placed_next;
    logic [10:0]   probes_reg, probes_next;
    logic          occ_reg, occ_next;
    logic [30:0]   rkey_reg, rkey_next;
    logic [31:0]   total_reg, total_next;
    logic [10:0]   inserts_reg, inserts_next;
    logic [31:0]   failures_reg, failures_next;

    // Slot memory: bit 31 marks the slot as used, bits 30:0 hold the key.
    logic [31:0]   slot_mem [TABLE_DEPTH];
    logic [31:0]   mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic [AW-1:0] mem_ra;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= slot_mem[mem_ra];
    end

    // Shared remainder unit: one restoring step per cycle.
    logic [DW-1:0] divisor;
    logic [DW:0]   trial;
    logic [DW-1:0] rem_step;
    logic          div_last;
    logic          accept;

    always_comb begin
        divisor  = (phase_reg == PH_KEYMOD) ? DW'(prime_eff) : DW'(size_eff);
        trial    = {rem_reg, num_reg[30]};
        rem_step = (trial >= {1'b0, divisor}) ? DW'(trial - {1'b0, divisor})
                                              : trial[DW-1:0];
        div_last = (cnt_reg == 5'd0);
        accept   = start && (state_reg == S_IDLE);
    end

    // Probe arithmetic.
    logic [SW:0]   idx_sum;
    logic [SW-1:0] idx_wrap;
    logic [SW:0]   inc_a;
    logic [SW:0]   inc_b;
    logic [SW-1:0] inc_quad;
    logic [SW-1:0] one_mod;
    logic          slot_free;
    logic          last_probe;
    logic [9:0]    step_val;
    logic [32:0]   total_sum;

    always_comb begin
        idx_sum  = {1'b0, idx_reg} + {1'b0, inc_reg};
        idx_wrap = (idx_sum >= {1'b0, size_eff}) ? SW'(idx_sum - {1'b0, size_eff})
                                                 : idx_sum[SW-1:0];
        inc_a    = {1'b0, inc_reg} + (SW+1)'(2);
        inc_b    = (inc_a >= {1'b0, size_eff}) ? (inc_a - {1'b0, size_eff}) : inc_a;
        inc_quad = (inc_b >= {1'b0, size_eff}) ? SW'(inc_b - {1'b0, size_eff})
                                               : inc_b[SW-1:0];
        one_mod  = (size_eff == SW'(1)) ? SW'(0) : SW'(1);
        slot_free  = !mem_q_reg[31];
        last_probe = ((c_reg + SW'(1)) == size_eff);
        step_val   = prime_eff - rem_step[9:0];
        total_sum  = {1'b0, total_reg} + 33'(c_reg);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    priority if (cmd.kind == KIND_INSERT) state_next = S_DIV;
                    else if (cmd.kind == KIND_CLEAR)      state_next = S_CLEAR;
                    else                                  state_next = S_READ_WAIT;
                end
            end
            S_CLEAR: begin
                if (clr_reg == LAST_ADDR) begin
                    state_next = clr_reply_reg ? S_RESPOND : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_last && (phase_reg == PH_STEP ||
                    (phase_reg == PH_HOME && probe_mode_reg != MODE_DOUBLE))) begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:  state_next = S_PROBE_CHK;
            S_PROBE_CHK: begin
                if (slot_free || last_probe) state_next = S_RESPOND;
                else                         state_next = S_PROBE_RD;
            end
            S_READ_WAIT: state_next = S_RESPOND;
            S_RESPOND:   state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        phase_next     = phase_reg;
        key_next       = key_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        inc_next       = inc_reg;
        c_next         = c_reg;
        clr_next       = clr_reg;
        clr_reply_next = clr_reply_reg;
        rd_ok_next     = rd_ok_reg;
        status_next    = status_reg;
        placed_next    = placed_reg;
        probes_next    = probes_reg;
        occ_next       = occ_reg;
        rkey_next      = rkey_reg;
        total_next     = total_reg;
        inserts_next   = inserts_reg;
        failures_next  = failures_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg[AW-1:0];
        mem_wd         = {1'b1, key_reg};
        mem_ra         = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                mem_ra = AW'(cmd.slot_index);
                if (accept) begin
                    key_next    = cmd.key;
                    num_next    = cmd.key;
                    rem_next    = '0;
                    cnt_next    = 5'd30;
                    phase_next  = PH_HOME;
                    c_next      = '0;
                    placed_next = '0;
                    probes_next = '0;
                    occ_next    = 1'b0;
                    rkey_next   = '0;
                    rd_ok_next  = (32'(cmd.slot_index) < TABLE_DEPTH);
                    priority if (cmd.kind == KIND_INSERT) begin
                        status_next = ST_INSERTED;
                    end else if (cmd.kind == KIND_CLEAR) begin
                        status_next    = ST_CLEARED;
                        clr_next       = '0;
                        clr_reply_next = 1'b1;
                        total_next     = '0;
                        inserts_next   = '0;
                        failures_next  = '0;
                    end else begin
                        status_next = ST_READ;
                    end
                end
            end
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = '0;
                clr_next = clr_reg + AW'(1);
            end
            S_DIV: begin
                num_next = {num_reg[29:0], 1'b0};
                rem_next = rem_step;
                cnt_next = cnt_reg - 5'd1;
                if (div_last) begin
                    rem_next = '0;
                    cnt_next = 5'd30;
                    unique case (phase_reg)
                        PH_HOME: begin
                            idx_next   = SW'(rem_step);
                            inc_next   = one_mod;
                            num_next   = key_reg;
                            phase_next = PH_KEYMOD;
                        end
                        PH_KEYMOD: begin
                            num_next   = 31'(step_val);
                            phase_next = PH_STEP;
                        end
                        PH_STEP: begin
                            inc_next = SW'(rem_step);
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE_RD: ;
            S_PROBE_CHK: begin
                if (slot_free) begin
                    mem_we       = 1'b1;
                    placed_next  = 10'(idx_reg);
                    probes_next  = 11'(c_reg);
                    total_next   = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
                    inserts_next = (inserts_reg == 11'h7FF) ? inserts_reg
                                                            : inserts_reg + 11'd1;
                end else if (last_probe) begin
                    status_next   = ST_FAILED;
                    probes_next   = 11'(size_eff);
                    failures_next = (failures_reg == 32'hFFFF_FFFF) ? failures_reg
                                                                    : failures_reg + 32'd1;
                end else begin
                    c_next   = c_reg + SW'(1);
                    idx_next = idx_wrap;
                    if (probe_mode_reg == MODE_QUAD) begin
                        inc_next = inc_quad;
                    end
                end
            end
            S_READ_WAIT: begin
                occ_next  = rd_ok_reg && mem_q_reg[31];
                rkey_next = (rd_ok_reg && mem_q_reg[31]) ? mem_q_reg[30:0] : '0;
            end
            S_RESPOND: begin
                clr_reply_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clr_reply_reg <= 1'b0;
            total_reg     <= '0;
            inserts_reg   <= '0;
            failures_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_reply_reg <= clr_reply_next;
            total_reg     <= total_next;
            inserts_reg   <= inserts_next;
            failures_reg  <= failures_next;
        end
    end

    always_ff @(posedge clk) begin
        phase_reg  <= phase_next;
        key_reg    <= key_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        inc_reg    <= inc_next;
        c_reg      <= c_next;
        rd_ok_reg  <= rd_ok_next;
        status_reg <= status_next;
        placed_reg <= placed_next;
        probes_reg <= probes_next;
        occ_reg    <= occ_next;
        rkey_reg   <= rkey_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESPOND);
    assign rsp  = '{status: status_reg, placed_slot: placed_reg,
                    probe_count: probes_reg, slot_occupied: occ_reg,
                    slot_key: rkey_reg, total_probes: total_reg,
                    insert_count: inserts_reg, failure_count: failures_reg};

    // The result strobe lasts a single cycle and never meets an idle block.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result given while idle");
    // A probe never addresses a slot outside the active table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE_RD) |-> (idx_reg < size_eff))
        else $error("probe index beyond table size");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

endmodule
